>>> rtl/sha1_message_digest_macros.svh
// Assertion macros shared by the SHA-1 digest RTL.
`ifndef SHA1_MESSAGE_DIGEST_MACROS_SVH
`define SHA1_MESSAGE_DIGEST_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, checked out of reset.
`define SHA1_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sha1 same-cycle check failed");
// Next-cycle implication, checked out of reset.
`define SHA1_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sha1 next-cycle check failed");
`else
`define SHA1_ASSERT_IMPL(label, ante, cons)
`define SHA1_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> rtl/sha1md_pkg.sv
// Types and constants for the SHA-1 digest block.
package sha1md_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD_MARK,
    ST_PAD_ZERO,
    ST_PAD_LEN,
    ST_ROUND,
    ST_FINAL,
    ST_OUT
  } sha1_state_t;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [31:0] H0_INIT = 32'h67452301;
  localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
  localparam logic [31:0] H2_INIT = 32'h98BADCFE;
  localparam logic [31:0] H3_INIT = 32'h10325476;
  localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

  localparam int unsigned NUM_WORDS  = 5;
  localparam int unsigned NUM_ROUNDS = 80;

  // Byte position in the block where the length field starts.
  localparam logic [5:0] LEN_POS   = 6'd56;
  localparam logic [5:0] LAST_POS  = 6'd63;
  localparam logic [7:0] PAD_MARK  = 8'h80;
  localparam logic [2:0] LAST_WIDX = 3'd4;
  localparam logic [2:0] LAST_LIDX = 3'd7;
  localparam logic [6:0] LAST_RND  = 7'd79;

endpackage

>>> rtl/sha1_message_digest.sv
// SHA-1 message digest: byte-serial absorb, one compression round per cycle.
//   Input channel (in_valid/in_ready): one beat per message byte. in_has_byte
//   says whether in_byte_value is a message byte; in_last ends the message.
//   A final beat with in_has_byte low hashes without adding a byte (so the
//   empty message works). A beat with neither has_byte nor last is a no-op.
//   Result channel (out_valid/out_ready): five beats per message, digest
//   word 0 (most significant) first, out_last_word high on word 4.
// Timing
//   A byte beat is taken while the block is idle. The beat that fills a
//   64-byte block starts a compression: 80 rounds through the single round
//   unit, then a fold of a..e into the chaining value; in_ready stays low
//   meanwhile, so no new byte is taken until the compression is done.
//   After the last beat the padder feeds 0x80, zeros and the 8 length bytes
//   one per cycle, pausing for each compression (one or two in all); then
//   the digest goes out from word 0, one word a cycle while out_ready is high.
// Reset and stalls
//   rst_n (synchronous, active low) loads the SHA-1 initial hash and clears
//   the bit count; the block buffer needs no clearing. in_ready is high only
//   while idle. A stalled receiver holds the block on the current digest
//   word; after word 4 is taken the block reinitializes for the next message.
module sha1_message_digest
  import sha1md_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_has_byte,
  input  logic [7:0]  in_byte_value,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

`include "sha1_message_digest_macros.svh"

  sha1_state_t state_r, state_nxt;
  sha1_state_t ret_r, ret_nxt;      // where to resume after a compression

  logic [31:0] cv_r [NUM_WORDS];    // chaining value
  logic [31:0] w_r  [16];           // block buffer / message schedule window
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [63:0] bit_len_r;
  logic [63:0] msg_bits_r;
  logic [6:0]  rnd_r;
  logic [2:0]  len_idx_r;
  logic [2:0]  widx_r;

  logic        absorb;
  logic [7:0]  abs_byte;
  logic [5:0]  pos;
  logic [2:0]  lsel;

  // round unit
  logic [31:0] f_w, k_w, sum_w, wnew_w, wx_w;

  assign pos  = bit_len_r[8:3];
  assign lsel = LAST_LIDX - len_idx_r;

  always_comb begin
    if (rnd_r < 7'd20) begin
      f_w = (b_r & c_r) | (~b_r & d_r);
      k_w = K0;
    end else if (rnd_r < 7'd40) begin
      f_w = b_r ^ c_r ^ d_r;
      k_w = K1;
    end else if (rnd_r < 7'd60) begin
      f_w = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      k_w = K2;
    end else begin
      f_w = b_r ^ c_r ^ d_r;
      k_w = K3;
    end
    sum_w  = {a_r[26:0], a_r[31:27]} + f_w + e_r + k_w + w_r[0];
    wx_w   = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
    wnew_w = {wx_w[30:0], wx_w[31]};
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    absorb    = 1'b0;
    abs_byte  = 8'h00;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          absorb    = in_has_byte;
          abs_byte  = in_byte_value;
          state_nxt = in_last ? ST_PAD_MARK : ST_IDLE;
        end
      end
      ST_PAD_MARK: begin
        absorb    = 1'b1;
        abs_byte  = PAD_MARK;
        state_nxt = ST_PAD_ZERO;
      end
      ST_PAD_ZERO: begin
        if (pos == LEN_POS) begin
          state_nxt = ST_PAD_LEN;
        end else begin
          absorb = 1'b1;
        end
      end
      ST_PAD_LEN: begin
        absorb    = 1'b1;
        abs_byte  = msg_bits_r[{lsel, 3'b000} +: 8];
        state_nxt = (len_idx_r == LAST_LIDX) ? ST_OUT : ST_PAD_LEN;
      end
      ST_ROUND: begin
        if (rnd_r == LAST_RND) begin
          state_nxt = ST_FINAL;
        end
      end
      ST_FINAL: begin
        state_nxt = ret_r;
      end
      ST_OUT: begin
        if (out_ready && widx_r == LAST_WIDX) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    // a byte landing in the last slot kicks off a compression first
    if (absorb && pos == LAST_POS) begin
      ret_nxt   = state_nxt;
      state_nxt = ST_ROUND;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ret_r   <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
    end
  end

  // control counters and chaining value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_len_r <= '0;
      rnd_r     <= '0;
      len_idx_r <= '0;
      widx_r    <= '0;
      cv_r[0]   <= H0_INIT;
      cv_r[1]   <= H1_INIT;
      cv_r[2]   <= H2_INIT;
      cv_r[3]   <= H3_INIT;
      cv_r[4]   <= H4_INIT;
    end else begin
      if (absorb) begin
        bit_len_r <= bit_len_r + 64'd8;
      end
      if (state_r == ST_ROUND) begin
        rnd_r <= rnd_r + 7'd1;
      end else begin
        rnd_r <= '0;
      end
      if (state_r == ST_PAD_MARK) begin
        len_idx_r <= '0;
      end else if (state_r == ST_PAD_LEN) begin
        len_idx_r <= len_idx_r + 3'd1;
      end
      if (state_r == ST_FINAL) begin
        cv_r[0] <= cv_r[0] + a_r;
        cv_r[1] <= cv_r[1] + b_r;
        cv_r[2] <= cv_r[2] + c_r;
        cv_r[3] <= cv_r[3] + d_r;
        cv_r[4] <= cv_r[4] + e_r;
      end
      if (state_r == ST_OUT && out_ready) begin
        if (widx_r == LAST_WIDX) begin
          widx_r    <= '0;
          bit_len_r <= '0;
          cv_r[0]   <= H0_INIT;
          cv_r[1]   <= H1_INIT;
          cv_r[2]   <= H2_INIT;
          cv_r[3]   <= H3_INIT;
          cv_r[4]   <= H4_INIT;
        end else begin
          widx_r <= widx_r + 3'd1;
        end
      end
    end
  end

  // datapath: byte shift-in, round shift, working variables
  always_ff @(posedge clk) begin
    if (state_r == ST_PAD_MARK) begin
      msg_bits_r <= bit_len_r;
    end
    if (absorb) begin
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= {w_r[i][23:0], w_r[i+1][31:24]};
      end
      w_r[15] <= {w_r[15][23:0], abs_byte};
      if (pos == LAST_POS) begin
        a_r <= cv_r[0];
        b_r <= cv_r[1];
        c_r <= cv_r[2];
        d_r <= cv_r[3];
        e_r <= cv_r[4];
      end
    end else if (state_r == ST_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= w_r[i+1];
      end
      w_r[15] <= wnew_w;
      a_r     <= sum_w;
      b_r     <= a_r;
      c_r     <= {b_r[1:0], b_r[31:2]};
      d_r     <= c_r;
      e_r     <= d_r;
    end
  end

  assign in_ready        = (state_r == ST_IDLE);
  assign out_valid       = (state_r == ST_OUT);
  assign out_digest_word = cv_r[widx_r];
  assign out_word_index  = widx_r;
  assign out_last_word   = (widx_r == LAST_WIDX);

  // padding must always leave the block boundary aligned before output
  `SHA1_ASSERT_IMPL(a_out_aligned, state_r == ST_OUT, bit_len_r[8:0] == 9'd0)
  `SHA1_ASSERT_IMPL(a_idx_range, out_valid, widx_r <= LAST_WIDX)
  `SHA1_ASSERT_NEXT(a_round_end, state_r == ST_ROUND && rnd_r == LAST_RND,
                    state_r == ST_FINAL)
  `SHA1_ASSERT_NEXT(a_msg_done, out_valid && out_ready && out_last_word,
                    in_ready && bit_len_r == 64'd0 && cv_r[0] == H0_INIT)
  `SHA1_ASSERT_IMPL(a_no_overlap, in_ready, !out_valid && rnd_r == 7'd0)

endmodule

>>> bench/tb_sha1_message_digest.sv
// Testbench for sha1_message_digest: byte beats in, checked digest words out.
`timescale 1ns / 100ps

module tb_sha1_message_digest;

  // Run limits, in clock cycles. The slowest possible run has every beat a
  // one-byte message behind the longest source gap, then its padding and
  // compression, and the longest sink stall on each digest word.
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 200;
  localparam int TARGET_ITEMS = 410;

  // One digest word as the result channel should show it.
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  widx;
    logic        fin;
  } digest_beat_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_has_byte;
  logic [7:0]  in_byte_value;
  logic        in_last;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  sha1_message_digest u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_has_byte     (in_has_byte),
    .in_byte_value   (in_byte_value),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

  // Predictor state: running hash, partial 64-byte chunk, message bit count.
  logic [31:0] chain_h [0:4];
  logic [7:0]  chunk_buf [0:63];
  logic [63:0] msg_bit_count;

  // Digest words predicted but not yet seen on the result channel.
  digest_beat_t pending_digest_words [$];

  int err_count = 0;
  int items_sent = 0;  // beats that carry a byte or end a message
  int src_gap_pct = 0;  // chance (%) of an idle burst before an input beat
  int sink_stall_pct = 0;  // chance (%) of a ready-low burst on the output
  int noop_pct = 0;  // chance (%) of a no-op beat between message bytes

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // SHA-1 predictor
  // ---------------------------------------------------------------------

  task automatic pred_restart();
    chain_h[0] = 32'h67452301;
    chain_h[1] = 32'hEFCDAB89;
    chain_h[2] = 32'h98BADCFE;
    chain_h[3] = 32'h10325476;
    chain_h[4] = 32'hC3D2E1F0;
    msg_bit_count = '0;
  endtask

  // 80-round compression of chunk_buf into chain_h.
  task automatic sha1_compress();
    logic [31:0] w [0:79];
    logic [31:0] a, b, c, d, e, f, k, sum, x;
    for (int t = 0; t < 16; t++)
      w[t] = {chunk_buf[4*t], chunk_buf[4*t+1], chunk_buf[4*t+2], chunk_buf[4*t+3]};
    for (int t = 16; t < 80; t++) begin
      x = w[t-3] ^ w[t-8] ^ w[t-14] ^ w[t-16];
      w[t] = {x[30:0], x[31]};
    end
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (int t = 0; t < 80; t++) begin
      if (t < 20) begin
        f = (b & c) | (~b & d);
        k = 32'h5A827999;
      end else if (t < 40) begin
        f = b ^ c ^ d;
        k = 32'h6ED9EBA1;
      end else if (t < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = 32'h8F1BBCDC;
      end else begin
        f = b ^ c ^ d;
        k = 32'hCA62C1D6;
      end
      sum = {a[26:0], a[31:27]} + f + e + k + w[t];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = sum;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endtask

  // Drop one byte into the chunk; a full chunk gets compressed.
  task automatic sha1_absorb(input logic [7:0] v);
    logic [5:0] pos;
    pos = msg_bit_count[8:3];
    chunk_buf[pos] = v;
    msg_bit_count += 64'd8;
    if (pos == 6'd63) sha1_compress();
  endtask

  // Padding, length field, then queue the five digest words.
  task automatic sha1_finish();
    logic [63:0] len_bits;
    digest_beat_t beat;
    len_bits = msg_bit_count;
    sha1_absorb(8'h80);
    while (msg_bit_count[8:3] != 6'd56) sha1_absorb(8'h00);
    for (int i = 0; i < 8; i++) sha1_absorb(len_bits[63 - 8*i -: 8]);
    for (int i = 0; i < 5; i++) begin
      beat.word = chain_h[i];
      beat.widx = 3'(i);
      beat.fin = (i == 4);
      pending_digest_words.push_back(beat);
    end
    pred_restart();
  endtask

  // ---------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------

  // Send one input beat and feed it to the predictor once accepted. Valid is
  // left high on return, so back-to-back beats never see it drop.
  task automatic send_beat(input logic has, input logic [7:0] val, input logic lst);
    if (src_gap_pct > 0 && $urandom_range(99) < src_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(16, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_has_byte <= has;
    in_byte_value <= val;
    in_last <= lst;
    do @(posedge clk); while (!in_ready);
    if (has) sha1_absorb(val);
    if (lst) sha1_finish();
    if (has || lst) items_sent++;
  endtask

  // A whole message of random bytes. With empty_tail the message ends on a
  // separate beat that carries no byte; an empty message always does.
  task automatic send_message(input int len, input bit empty_tail);
    for (int i = 0; i < len; i++) begin
      if (noop_pct > 0 && $urandom_range(99) < noop_pct)
        send_beat(1'b0, 8'($urandom_range(255)), 1'b0);
      send_beat(1'b1, 8'($urandom_range(255)), (i == len - 1) && !empty_tail);
    end
    if (len == 0 || empty_tail) send_beat(1'b0, 8'($urandom_range(255)), 1'b1);
  endtask

  // ---------------------------------------------------------------------
  // Output side: ready stalls and the result check
  // ---------------------------------------------------------------------

  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_stall_pct > 0 && $urandom_range(99) < sink_stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(16, 1)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  digest_beat_t want;

  // Every accepted digest beat is matched against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_digest_words.size() == 0) begin
        $error("unexpected digest beat: word %h index %0d", out_digest_word,
               out_word_index);
        err_count++;
      end else begin
        want = pending_digest_words.pop_front();
        if (out_digest_word !== want.word) begin
          $error("digest_word: expected %h, got %h", want.word, out_digest_word);
          err_count++;
        end
        if (out_word_index !== want.widx) begin
          $error("word_index: expected %0d, got %0d", want.widx, out_word_index);
          err_count++;
        end
        if (out_last_word !== want.fin) begin
          $error("last_word: expected %0b, got %0b", want.fin, out_last_word);
          err_count++;
        end
      end
    end
  end

  // Hard stop if the block hangs.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb_sha1_message_digest: errors");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Short hand-built messages: empty message, byte extremes, a no-op beat,
  // last on a byte beat and last on an empty beat.
  task automatic test_short_messages();
    src_gap_pct = 30;
    sink_stall_pct = 30;
    send_beat(1'b0, 8'h00, 1'b1);  // empty message
    send_beat(1'b1, 8'h61, 1'b0);  // "abc", last on the byte
    send_beat(1'b1, 8'h62, 1'b0);
    send_beat(1'b1, 8'h63, 1'b1);
    send_beat(1'b0, 8'hFF, 1'b0);  // no-op beat between messages
    send_beat(1'b1, 8'hFF, 1'b1);  // one byte, all ones
    send_beat(1'b1, 8'h00, 1'b0);  // one byte, all zeros, then empty tail
    send_beat(1'b0, 8'hA5, 1'b0);
    send_beat(1'b0, 8'h5A, 1'b1);
    send_beat(1'b1, 8'hFF, 1'b0);  // two bytes with an empty tail
    send_beat(1'b1, 8'h00, 1'b0);
    send_beat(1'b0, 8'h00, 1'b1);
  endtask

  // Lengths where the pad/length field straddles a chunk edge: 55 fits in
  // one chunk, 56 needs a second, 64 is a full chunk before padding.
  task automatic test_pad_boundaries();
    src_gap_pct = 15;
    sink_stall_pct = 40;
    noop_pct = 3;
    send_message(55, 1'b0);
    send_message(56, 1'b1);
    send_message(64, 1'($urandom_range(1)));
  endtask

  // Random lengths, weighted toward short messages and chunk edges. Idling
  // is reshuffled per message, sometimes switched off entirely.
  task automatic test_random_messages(input int stop_at);
    int len;
    int pick;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 45) len = $urandom_range(20);
      else if (pick < 75) len = $urandom_range(57, 54) + 8 * $urandom_range(1);
      else if (pick < 95) len = $urandom_range(70, 21);
      else len = $urandom_range(130, 100);
      if (len > stop_at - items_sent) len = stop_at - items_sent;
      if ($urandom_range(3) == 0) begin
        src_gap_pct = 0;
        sink_stall_pct = 0;
      end else begin
        src_gap_pct = $urandom_range(40);
        sink_stall_pct = $urandom_range(60);
      end
      noop_pct = $urandom_range(1) ? 5 : 0;
      send_message(len, $urandom_range(3) == 0);
    end
  endtask

  // Tail of the run with no idling on either side.
  task automatic test_no_idle();
    src_gap_pct = 0;
    sink_stall_pct = 0;
    noop_pct = 0;
    send_message(0, 1'b1);
    send_message(1, 1'b0);
    send_message(64, 1'b0);
    send_message(3, 1'b1);
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_has_byte <= 1'b0;
    in_byte_value <= 8'h00;
    in_last <= 1'b0;
    pred_restart();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_short_messages();
    test_pad_boundaries();
    test_random_messages(TARGET_ITEMS - 70);
    test_no_idle();

    in_valid <= 1'b0;
    while (pending_digest_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("tb_sha1_message_digest: clean");
    else
      $display("tb_sha1_message_digest: errors");
    $finish;
  end

endmodule

>>> sha1_message_digest.f
+incdir+rtl
rtl/sha1md_pkg.sv
rtl/sha1_message_digest.sv
bench/tb_sha1_message_digest.sv
